@@ src/rbc_pkg.sv @@
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types and constants for the rotated box corner pipeline: field
// widths, register indexes, the CORDIC arctangent table and the widths of
// the product, rounding and saturation stages.
// ----------------------------------------------------------------------------
package rbc_pkg;

  // Field widths of the ports.
  localparam int COORD_W    = 24;
  localparam int SIZE_W     = 20;
  localparam int HEAD_W     = 16;
  localparam int CFG_ADDR_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_HEIGHT = 2'd1;

  // Stored size forms: three times the width and twice the height.
  localparam int W3_W = SIZE_W + 2;
  localparam int H2_W = SIZE_W + 1;

  // Heading scaling: a full turn is 2^ANGLE_BITS, mapped onto 32 bits.
  localparam int          ANGLE_BITS  = 16;
  localparam int          ANGLE_SHIFT = 32 - ANGLE_BITS;
  localparam logic [31:0] ANGLE_MASK  = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  // CORDIC rotation pipeline.
  localparam int CORDIC_STEPS    = 20;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int ROT_W           = 33;

  localparam logic signed [ROT_W-1:0] GAIN_Q30 = 33'sd652032874;

  // Arctangent of 2^-i in units of a full turn scaled to 2^32.
  localparam logic signed [ROT_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
    33'sd21354465,  33'sd10679838,  33'sd5340245,   33'sd2670163,  33'sd1335087,
    33'sd667544,    33'sd333772,    33'sd166886,    33'sd83443,    33'sd41722,
    33'sd20861,     33'sd10430,     33'sd5215,      33'sd2608,     33'sd1304
  };

  // Product and corner sum widths.
  localparam int PROD_W = W3_W + 1 + ROT_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  // Corner coordinate order on the corner bus.
  localparam int NUM_COORDS = 8;
  localparam int CRN_FL_X   = 0;
  localparam int CRN_FL_Y   = 1;
  localparam int CRN_FR_X   = 2;
  localparam int CRN_FR_Y   = 3;
  localparam int CRN_RL_X   = 4;
  localparam int CRN_RL_Y   = 5;
  localparam int CRN_RR_X   = 6;
  localparam int CRN_RR_Y   = 7;

  // Rounding: divide by 6 * 2^30 as a shift by 31 and a divide by 3.
  localparam int             DIV_SHIFT   = 31;
  localparam logic [SUM_W:0] ROUND_BIAS  = (SUM_W + 1)'(64'd3 << 30);
  localparam int             NUM_W       = SUM_W + 1 - DIV_SHIFT;
  localparam int             RECIP_W     = 26;
  localparam int             RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP_THIRD = 26'd44739243;
  localparam int             MULQ_W      = NUM_W + RECIP_W;
  localparam int             Q_W         = MULQ_W - RECIP_SHIFT;
  localparam int             RES_W       = Q_W + 2;

  // Pipeline latency in register stages.
  localparam int CORDIC_LAT   = CORDIC_STAGES + 2;
  localparam int CORNER_LAT   = 2;
  localparam int ROUND_LAT    = 3;
  localparam int PIPE_LATENCY = CORDIC_LAT + CORNER_LAT + ROUND_LAT;

  // Pivot position carried alongside the angle work.
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } pose_t;

  // CORDIC vector and residual angle.
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } rot_t;

endpackage

@@ src/rbc_cordic.sv @@
// ----------------------------------------------------------------------------
// rbc_cordic
// Pipelined CORDIC sine and cosine of a binary angle. One prep stage folds
// the angle into the right half plane, ten stages run two rotations each,
// and a final stage undoes the fold. The pivot position rides along.
// ----------------------------------------------------------------------------
module rbc_cordic
  import rbc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  logic [HEAD_W-1:0]       heading_i,
  input  pose_t                   pose_i,
  output logic                    vld_o,
  output logic signed [ROT_W-1:0] cos_o,
  output logic signed [ROT_W-1:0] sin_o,
  output pose_t                   pose_o
);

  rot_t                    rot_r   [CORDIC_STAGES+1];
  rot_t                    rot_nxt [CORDIC_STAGES];
  pose_t                   pose_r  [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0]  vld_r;
  logic [CORDIC_STAGES:0]  flip_r;
  rot_t                    prep_nxt;
  logic                    flip_nxt;
  logic [31:0]             ang_a;
  logic [31:0]             ang_z;
  logic signed [ROT_W-1:0] cos_r;
  logic signed [ROT_W-1:0] sin_r;
  logic                    fin_vld_r;
  pose_t                   fin_pose_r;

  // Scale the heading to 32 bits and fold the left half plane by half a turn.
  always_comb begin
    ang_a    = (32'(heading_i) & ANGLE_MASK) << ANGLE_SHIFT;
    flip_nxt = (ang_a[31:30] == 2'b01) || (ang_a[31:30] == 2'b10);
    ang_z    = {ang_a[31] ^ flip_nxt, ang_a[30:0]};
    prep_nxt = '{x: GAIN_Q30, y: '0, z: ROT_W'(signed'(ang_z))};
  end

  // Two rotation steps per stage, driven by the sign of the residual angle.
  always_comb begin
    logic signed [ROT_W-1:0] xv;
    logic signed [ROT_W-1:0] yv;
    logic signed [ROT_W-1:0] zv;
    logic signed [ROT_W-1:0] xs;
    logic signed [ROT_W-1:0] ys;
    for (int g = 0; g < CORDIC_STAGES; g++) begin
      xv = rot_r[g].x;
      yv = rot_r[g].y;
      zv = rot_r[g].z;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        xs = xv >>> (g * STEPS_PER_STAGE + k);
        ys = yv >>> (g * STEPS_PER_STAGE + k);
        if (!zv[ROT_W-1]) begin
          xv = xv - ys;
          yv = yv + xs;
          zv = zv - ATAN_TAB[g * STEPS_PER_STAGE + k];
        end else begin
          xv = xv + ys;
          yv = yv - xs;
          zv = zv + ATAN_TAB[g * STEPS_PER_STAGE + k];
        end
      end
      rot_nxt[g] = '{x: xv, y: yv, z: zv};
    end
  end

  // Valid bits of the rotation stages and the final stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fin_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[CORDIC_STAGES-1:0], vld_i};
      fin_vld_r <= vld_r[CORDIC_STAGES];
    end
  end

  // Stage data, and the final stage that negates after a fold.
  always_ff @(posedge clk) begin
    rot_r[0]  <= prep_nxt;
    flip_r[0] <= flip_nxt;
    pose_r[0] <= pose_i;
    for (int g = 0; g < CORDIC_STAGES; g++) begin
      rot_r[g+1]  <= rot_nxt[g];
      flip_r[g+1] <= flip_r[g];
      pose_r[g+1] <= pose_r[g];
    end
    cos_r      <= flip_r[CORDIC_STAGES] ? -rot_r[CORDIC_STAGES].x : rot_r[CORDIC_STAGES].x;
    sin_r      <= flip_r[CORDIC_STAGES] ? -rot_r[CORDIC_STAGES].y : rot_r[CORDIC_STAGES].y;
    fin_pose_r <= pose_r[CORDIC_STAGES];
  end

  assign vld_o  = fin_vld_r;
  assign cos_o  = cos_r;
  assign sin_o  = sin_r;
  assign pose_o = fin_pose_r;

endmodule

@@ src/rbc_corners.sv @@
// ----------------------------------------------------------------------------
// rbc_corners
// Rotates the box offsets: four products of the scaled size with sine and
// cosine, then one add or subtract per corner coordinate. Results stay
// scaled by 6 * 2^30 for the rounding stage.
// ----------------------------------------------------------------------------
module rbc_corners
  import rbc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  logic signed [ROT_W-1:0] cos_i,
  input  logic signed [ROT_W-1:0] sin_i,
  input  pose_t                   pose_i,
  input  logic [W3_W-1:0]         box_w3_i,
  input  logic [H2_W-1:0]         box_h2_i,
  output logic                    vld_o,
  output logic signed [SUM_W-1:0] coord_o [NUM_COORDS],
  output pose_t                   pose_o
);

  logic signed [W3_W:0]     w3_s;
  logic signed [H2_W:0]     h2_s;
  logic signed [PROD_W-1:0] w3c_r;
  logic signed [PROD_W-1:0] w3s_r;
  logic signed [PROD_W-1:0] h2c_r;
  logic signed [PROD_W-1:0] h2s_r;
  logic signed [SUM_W-1:0]  w3c_e;
  logic signed [SUM_W-1:0]  w3s_e;
  logic signed [SUM_W-1:0]  h2c_e;
  logic signed [SUM_W-1:0]  h2s_e;
  logic signed [SUM_W-1:0]  coord_nxt [NUM_COORDS];
  logic signed [SUM_W-1:0]  coord_r   [NUM_COORDS];
  logic [1:0]               vld_r;
  pose_t                    pose1_r;
  pose_t                    pose2_r;

  assign w3_s = signed'({1'b0, box_w3_i});
  assign h2_s = signed'({1'b0, box_h2_i});

  // Sign-extended products for the corner sums.
  assign w3c_e = SUM_W'(w3c_r);
  assign w3s_e = SUM_W'(w3s_r);
  assign h2c_e = SUM_W'(h2c_r);
  assign h2s_e = SUM_W'(h2s_r);

  // Front corners sit at twice the rear distance, on the other side.
  always_comb begin
    coord_nxt[CRN_FL_X] = (h2s_e <<< 1) - w3c_e;
    coord_nxt[CRN_FL_Y] = -w3s_e - (h2c_e <<< 1);
    coord_nxt[CRN_FR_X] = w3c_e + (h2s_e <<< 1);
    coord_nxt[CRN_FR_Y] = w3s_e - (h2c_e <<< 1);
    coord_nxt[CRN_RL_X] = -w3c_e - h2s_e;
    coord_nxt[CRN_RL_Y] = h2c_e - w3s_e;
    coord_nxt[CRN_RR_X] = w3c_e - h2s_e;
    coord_nxt[CRN_RR_Y] = w3s_e + h2c_e;
  end

  // Valid bits of the product and sum stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], vld_i};
    end
  end

  // Product stage, then sum stage.
  always_ff @(posedge clk) begin
    w3c_r   <= PROD_W'(w3_s) * PROD_W'(cos_i);
    w3s_r   <= PROD_W'(w3_s) * PROD_W'(sin_i);
    h2c_r   <= PROD_W'(h2_s) * PROD_W'(cos_i);
    h2s_r   <= PROD_W'(h2_s) * PROD_W'(sin_i);
    pose1_r <= pose_i;
    for (int k = 0; k < NUM_COORDS; k++) begin
      coord_r[k] <= coord_nxt[k];
    end
    pose2_r <= pose1_r;
  end

  assign vld_o   = vld_r[1];
  assign coord_o = coord_r;
  assign pose_o  = pose2_r;

endmodule

@@ src/rbc_round.sv @@
// ----------------------------------------------------------------------------
// rbc_round
// Divides one scaled corner coordinate by 6 * 2^30, rounding half away from
// zero, adds the pivot and saturates to the coordinate range. Three stages:
// biased magnitude, reciprocal multiply by one third, signed add and clamp.
// ----------------------------------------------------------------------------
module rbc_round
  import rbc_pkg::*;
(
  input  logic                      clk,
  input  logic signed [SUM_W-1:0]   p_i,
  input  logic signed [COORD_W-1:0] pos_i,
  output logic signed [COORD_W-1:0] coord_o
);

  localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'((2 ** (COORD_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] SAT_MIN = RES_W'(-(2 ** (COORD_W - 1)));

  logic [SUM_W:0]            p_ext;
  logic [SUM_W:0]            biased;
  logic                      neg;
  logic [NUM_W-1:0]          num_r;
  logic                      neg1_r;
  logic signed [COORD_W-1:0] pos1_r;
  logic [MULQ_W-1:0]         prod;
  logic [Q_W-1:0]            quo_r;
  logic                      neg2_r;
  logic signed [COORD_W-1:0] pos2_r;
  logic signed [RES_W-1:0]   pos_ext;
  logic signed [RES_W-1:0]   quo_ext;
  logic signed [RES_W-1:0]   res;
  logic signed [COORD_W-1:0] coord_nxt;
  logic signed [COORD_W-1:0] coord_r;

  // Magnitude plus half the divisor, then drop the power-of-two part.
  always_comb begin
    neg    = p_i[SUM_W-1];
    p_ext  = (SUM_W + 1)'(p_i);
    biased = neg ? (ROUND_BIAS - p_ext) : (p_ext + ROUND_BIAS);
  end

  // Divide by three through a multiply by the rounded-up reciprocal.
  assign prod = MULQ_W'(num_r) * MULQ_W'(RECIP_THIRD);

  // Apply the sign, add the pivot and clamp.
  always_comb begin
    pos_ext = RES_W'(pos2_r);
    quo_ext = signed'(RES_W'(quo_r));
    res     = neg2_r ? (pos_ext - quo_ext) : (pos_ext + quo_ext);
    if (res > SAT_MAX) begin
      coord_nxt = SAT_MAX[COORD_W-1:0];
    end else if (res < SAT_MIN) begin
      coord_nxt = SAT_MIN[COORD_W-1:0];
    end else begin
      coord_nxt = res[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= biased[SUM_W:DIV_SHIFT];
    neg1_r  <= neg;
    pos1_r  <= pos_i;
    quo_r   <= prod[MULQ_W-1:RECIP_SHIFT];
    neg2_r  <= neg1_r;
    pos2_r  <= pos1_r;
    coord_r <= coord_nxt;
  end

  assign coord_o = coord_r;

endmodule

@@ src/rotated_box_corners.sv @@
// ----------------------------------------------------------------------------
// rotated_box_corners
// Four world corners of a rectangle of configured width and height, placed
// at a pivot position and rotated by a binary-angle heading.
// ----------------------------------------------------------------------------
//  Channel   Ports                              Handshake
//  input     in_pos_x, in_pos_y, in_heading     taken when start && !busy
//  result    out_front_left_x .. out_rear_right_y   one cycle, out_strobe
//  config    cfg_we, cfg_addr, cfg_wdata        written when cfg_we
//
// One item enters every cycle while busy is low; each result passes through
// the ten two-step CORDIC stages plus seven more stages for angle fold,
// sign fix, products, sums and the three rounding stages.
// Reset is synchronous and clears the valid bits and both size registers;
// busy is high during reset and clears at the edge that samples rst_n high.
// The result side has no backpressure, so nothing in the pipe ever waits.
// ----------------------------------------------------------------------------
module rotated_box_corners
  import rbc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic [HEAD_W-1:0]         in_heading,
  output logic                      out_strobe,
  output logic signed [COORD_W-1:0] out_front_left_x,
  output logic signed [COORD_W-1:0] out_front_left_y,
  output logic signed [COORD_W-1:0] out_front_right_x,
  output logic signed [COORD_W-1:0] out_front_right_y,
  output logic signed [COORD_W-1:0] out_rear_left_x,
  output logic signed [COORD_W-1:0] out_rear_left_y,
  output logic signed [COORD_W-1:0] out_rear_right_x,
  output logic signed [COORD_W-1:0] out_rear_right_y,
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [SIZE_W-1:0]         cfg_wdata
);

  logic                      busy_r;
  logic                      in_accept;
  logic [W3_W-1:0]           box_w3_r;
  logic [W3_W-1:0]           box_w3_nxt;
  logic [H2_W-1:0]           box_h2_r;
  logic [H2_W-1:0]           box_h2_nxt;
  pose_t                     in_pose;
  logic                      rot_vld;
  logic signed [ROT_W-1:0]   rot_cos;
  logic signed [ROT_W-1:0]   rot_sin;
  pose_t                     rot_pose;
  logic                      crn_vld;
  logic signed [SUM_W-1:0]   crn_coord [NUM_COORDS];
  pose_t                     crn_pose;
  logic signed [COORD_W-1:0] res_coord [NUM_COORDS];
  logic [ROUND_LAT-1:0]      rnd_vld_r;

  // Accept handshake.
  assign in_accept = start && !busy_r;
  assign busy      = busy_r;
  assign in_pose   = '{pos_x: in_pos_x, pos_y: in_pos_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Size registers hold three times the width and twice the height.
  always_comb begin
    box_w3_nxt = box_w3_r;
    box_h2_nxt = box_h2_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_BOX_WIDTH:  box_w3_nxt = W3_W'(cfg_wdata) + W3_W'({cfg_wdata, 1'b0});
        REG_BOX_HEIGHT: box_h2_nxt = {cfg_wdata, 1'b0};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_w3_r <= '0;
      box_h2_r <= '0;
    end else begin
      box_w3_r <= box_w3_nxt;
      box_h2_r <= box_h2_nxt;
    end
  end

  // Sine and cosine of the heading.
  rbc_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (in_accept),
    .heading_i (in_heading),
    .pose_i    (in_pose),
    .vld_o     (rot_vld),
    .cos_o     (rot_cos),
    .sin_o     (rot_sin),
    .pose_o    (rot_pose)
  );

  // Rotated corner offsets, still scaled.
  rbc_corners u_corners (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (rot_vld),
    .cos_i    (rot_cos),
    .sin_i    (rot_sin),
    .pose_i   (rot_pose),
    .box_w3_i (box_w3_r),
    .box_h2_i (box_h2_r),
    .vld_o    (crn_vld),
    .coord_o  (crn_coord),
    .pose_o   (crn_pose)
  );

  // One rounding lane per coordinate; even lanes are x, odd lanes are y.
  for (genvar k = 0; k < NUM_COORDS; k++) begin : g_round
    rbc_round u_round (
      .clk     (clk),
      .p_i     (crn_coord[k]),
      .pos_i   (((k % 2) == 0) ? crn_pose.pos_x : crn_pose.pos_y),
      .coord_o (res_coord[k])
    );
  end

  // Valid bits alongside the rounding lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_vld_r <= '0;
    end else begin
      rnd_vld_r <= {rnd_vld_r[ROUND_LAT-2:0], crn_vld};
    end
  end

  assign out_strobe        = rnd_vld_r[ROUND_LAT-1];
  assign out_front_left_x  = res_coord[CRN_FL_X];
  assign out_front_left_y  = res_coord[CRN_FL_Y];
  assign out_front_right_x = res_coord[CRN_FR_X];
  assign out_front_right_y = res_coord[CRN_FR_Y];
  assign out_rear_left_x   = res_coord[CRN_RL_X];
  assign out_rear_left_y   = res_coord[CRN_RL_Y];
  assign out_rear_right_x  = res_coord[CRN_RR_X];
  assign out_rear_right_y  = res_coord[CRN_RR_Y];

`ifndef SYNTHESIS
  // Every taken item comes out after the full pipeline depth.
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##PIPE_LATENCY out_strobe)
    else $error("item taken but no result after pipeline latency");

  // No result appears without an item taken one pipeline depth earlier.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_accept, PIPE_LATENCY))
    else $error("result strobe without a matching item");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotated box corner testbench
// Drives poses into the corner pipeline, one item per start handshake, and
// checks each result strobe against a CORDIC and rounding model kept here.
// The box size registers are rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module testbench
  import rbc_pkg::*;
;

  localparam int STALL_LIMIT   = 1000;
  localparam int GAP_PERCENT   = 13;
  localparam int RAND_PER_SET  = 235;
  localparam int NUM_RAND_SETS = 8;

  // Indexes outside the register map; writes to them must be dropped.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [COORD_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] POS_MIN = -24'sh800000;
  localparam logic [SIZE_W-1:0]         SIZE_MAX = '1;

  // Rotation gain and arctangent steps, a full turn scaled to 2^32.
  localparam longint ROT_GAIN_Q30 = 64'sd652032874;
  localparam longint ATAN_TURN [20] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [HEAD_W-1:0]         heading;
  } pose_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] fl_x;
    logic signed [COORD_W-1:0] fl_y;
    logic signed [COORD_W-1:0] fr_x;
    logic signed [COORD_W-1:0] fr_y;
    logic signed [COORD_W-1:0] rl_x;
    logic signed [COORD_W-1:0] rl_y;
    logic signed [COORD_W-1:0] rr_x;
    logic signed [COORD_W-1:0] rr_y;
  } corner_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] in_pos_x = '0;
  logic signed [COORD_W-1:0] in_pos_y = '0;
  logic [HEAD_W-1:0]         in_heading = '0;
  logic out_strobe;
  logic signed [COORD_W-1:0] out_front_left_x, out_front_left_y;
  logic signed [COORD_W-1:0] out_front_right_x, out_front_right_y;
  logic signed [COORD_W-1:0] out_rear_left_x, out_rear_left_y;
  logic signed [COORD_W-1:0] out_rear_right_x, out_rear_right_y;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [SIZE_W-1:0]     cfg_wdata = '0;

  pose_item_t  pose_backlog[$];
  corner_set_t pending_corners[$];
  pose_item_t  next_pose;
  logic [SIZE_W-1:0] model_width = '0;
  logic [SIZE_W-1:0] model_height = '0;
  bit item_taken = 1'b0;
  bit no_gaps = 1'b0;
  int poses_queued = 0;
  int poses_taken = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;

  rotated_box_corners dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_heading        (in_heading),
    .out_strobe        (out_strobe),
    .out_front_left_x  (out_front_left_x),
    .out_front_left_y  (out_front_left_y),
    .out_front_right_x (out_front_right_x),
    .out_front_right_y (out_front_right_y),
    .out_rear_left_x   (out_rear_left_x),
    .out_rear_left_y   (out_rear_left_y),
    .out_rear_right_x  (out_rear_right_x),
    .out_rear_right_y  (out_rear_right_y),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Cosine and sine of a binary angle in Q30. Headings in the left half
  // plane are turned by half a circle first and the signs fixed afterwards.
  function automatic void heading_cos_sin(input logic [HEAD_W-1:0] hd,
                                          output longint cos_q30,
                                          output longint sin_q30);
    logic [31:0] ang;
    bit flip;
    longint x, y, z, xs, ys;
    ang = (32'(hd) & ANGLE_MASK) << ANGLE_SHIFT;
    flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    if (flip) begin
      ang = ang - 32'h8000_0000;
    end
    z = longint'(signed'(ang));
    x = ROT_GAIN_Q30;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TURN[i];
      end
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  // Divide a six-times-scaled Q30 offset down to the coordinate grid,
  // rounding half away from zero, then add the pivot and saturate.
  function automatic logic signed [COORD_W-1:0] place_coord(input longint prod,
                                                            input longint pivot);
    longint div, q, r;
    div = 64'sd6 <<< 30;
    q = (prod >= 0) ? (prod + div / 2) / div : -((-prod + div / 2) / div);
    r = pivot + q;
    if (r > longint'(POS_MAX)) begin
      r = longint'(POS_MAX);
    end
    if (r < longint'(POS_MIN)) begin
      r = longint'(POS_MIN);
    end
    return COORD_W'(r);
  endfunction

  // Four rotated corners for one pose under the current box size.
  function automatic corner_set_t box_corners(input pose_item_t p);
    longint c, s, w3;
    longint dx[4];
    longint dy[4];
    logic signed [COORD_W-1:0] coord[8];
    corner_set_t cs;
    heading_cos_sin(p.heading, c, s);
    w3 = 3 * longint'(model_width);
    dx = '{-w3, w3, -w3, w3};
    dy = '{-4 * longint'(model_height), -4 * longint'(model_height),
           2 * longint'(model_height), 2 * longint'(model_height)};
    for (int k = 0; k < 4; k++) begin
      coord[2 * k]     = place_coord(dx[k] * c - dy[k] * s, longint'(p.pos_x));
      coord[2 * k + 1] = place_coord(dx[k] * s + dy[k] * c, longint'(p.pos_y));
    end
    cs.fl_x = coord[0];
    cs.fl_y = coord[1];
    cs.fr_x = coord[2];
    cs.fr_y = coord[3];
    cs.rl_x = coord[4];
    cs.rl_y = coord[5];
    cs.rr_x = coord[6];
    cs.rr_y = coord[7];
    return cs;
  endfunction

  task automatic check_coord(input string name, input logic signed [COORD_W-1:0] want,
                             input logic signed [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: offers the next queued pose once the previous one was taken.
  always @(negedge clk) begin
    if (rst_n && (!start || item_taken)) begin
      if (pose_backlog.size() != 0 &&
          (no_gaps || $urandom_range(0, 99) >= GAP_PERCENT)) begin
        next_pose = pose_backlog.pop_front();
        in_pos_x   <= next_pose.pos_x;
        in_pos_y   <= next_pose.pos_y;
        in_heading <= next_pose.heading;
        start      <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: tracks register writes, predicts each accepted item and
  // checks every result strobe against the oldest prediction.
  always @(posedge clk) begin
    item_taken = rst_n && start && !busy;
    if (!rst_n) begin
      model_width  = '0;
      model_height = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_BOX_WIDTH:  model_width = cfg_wdata;
          REG_BOX_HEIGHT: model_height = cfg_wdata;
          default: ;
        endcase
      end
      if (item_taken) begin
        pending_corners.insert(pending_corners.size(),
                               box_corners('{in_pos_x, in_pos_y, in_heading}));
        poses_taken++;
      end
      if (out_strobe === 1'b1) begin
        if (pending_corners.size() == 0) begin
          $error("result strobe with no item outstanding");
          mismatch_count++;
        end else begin
          corner_set_t want;
          want = pending_corners.pop_front();
          check_coord("front_left_x", want.fl_x, out_front_left_x);
          check_coord("front_left_y", want.fl_y, out_front_left_y);
          check_coord("front_right_x", want.fr_x, out_front_right_x);
          check_coord("front_right_y", want.fr_y, out_front_right_y);
          check_coord("rear_left_x", want.rl_x, out_rear_left_x);
          check_coord("rear_left_y", want.rl_y, out_rear_left_y);
          check_coord("rear_right_x", want.rr_x, out_rear_right_x);
          check_coord("rear_right_y", want.rr_y, out_rear_right_y);
        end
      end
      // Watchdog on cycles where neither side moves an item.
      if (item_taken || out_strobe === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("rotated_box_corners: mismatch");
        $finish;
      end
    end
  end

  task automatic queue_pose(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic [HEAD_W-1:0] hd);
    pose_item_t item;
    item = '{x, y, hd};
    pose_backlog.insert(pose_backlog.size(), item);
    poses_queued++;
  endtask

  // Random pose: mostly uniform, with some near the saturation limits and
  // some headings close to multiples of an eighth of a turn.
  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0:       return POS_MAX - COORD_W'($urandom_range(0, 4095));
      1:       return POS_MIN + COORD_W'($urandom_range(0, 4095));
      2:       return COORD_W'($urandom_range(0, 511)) - 24'sd256;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [HEAD_W-1:0] random_heading();
    if ($urandom_range(0, 9) < 3) begin
      return HEAD_W'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
    end
    return HEAD_W'($urandom);
  endfunction

  // Register write, issued at a falling edge; the caller lowers cfg_we.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // Wait at falling edges until every queued pose was taken and answered.
  task automatic drain_pipe();
    while (poses_taken != poses_queued || pending_corners.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Stimulus: directed poses at reset size and at maximum size, then
  // random phases under a range of box sizes.
  initial begin
    logic [SIZE_W-1:0] w, h;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero size after reset: every corner equals the pivot.
    queue_pose(POS_MAX, POS_MIN, 16'd0);
    queue_pose(POS_MIN, POS_MAX, 16'd65535);
    queue_pose(24'sd0, 24'sd0, 16'd12345);
    queue_pose(-24'sd1, -24'sd1, 16'd32768);
    drain_pipe();

    // Largest box, plus writes to spare indexes that must be ignored.
    write_reg(REG_BOX_WIDTH, SIZE_MAX);
    write_reg(REG_BOX_HEIGHT, SIZE_MAX);
    write_reg(REG_SPARE_A, SIZE_W'($urandom));
    write_reg(REG_SPARE_B, '0);
    cfg_we <= 1'b0;
    queue_pose(24'sd0, 24'sd0, 16'd0);
    queue_pose(24'sd0, 24'sd0, 16'd16384);
    queue_pose(24'sd0, 24'sd0, 16'd32768);
    queue_pose(24'sd0, 24'sd0, 16'd49152);
    queue_pose(24'sd0, 24'sd0, 16'd8192);
    queue_pose(24'sd0, 24'sd0, 16'd65535);
    queue_pose(24'sd0, 24'sd0, 16'd1);
    queue_pose(POS_MAX, POS_MAX, 16'd0);
    queue_pose(POS_MIN, POS_MIN, 16'd0);
    queue_pose(POS_MAX, POS_MIN, 16'd16384);
    queue_pose(POS_MIN, POS_MAX, 16'd32768);
    queue_pose(POS_MAX, POS_MAX, 16'd40960);
    queue_pose(POS_MIN, POS_MIN, 16'd24576);
    queue_pose(POS_MAX - 24'sd100, POS_MIN + 24'sd100, 16'd57344);
    queue_pose(24'sd1234, -24'sd5678, 16'd16383);
    queue_pose(-24'sd1, 24'sd1, 16'd49153);
    drain_pipe();

    // Random phases; one of them runs with no input gaps at all.
    for (int ph = 0; ph < NUM_RAND_SETS; ph++) begin
      case (ph)
        0: begin w = '0; h = SIZE_MAX; end
        1: begin w = SIZE_MAX; h = '0; end
        2: begin w = SIZE_W'($urandom_range(0, 4095)); h = SIZE_W'($urandom_range(0, 4095)); end
        3: begin w = SIZE_W'($urandom); h = SIZE_W'($urandom); end
        4: begin w = 20'd1; h = 20'd1; end
        5: begin w = 20'd1024; h = 20'd768; end
        default: begin w = SIZE_W'($urandom); h = SIZE_W'($urandom); end
      endcase
      write_reg(REG_BOX_WIDTH, w);
      write_reg(REG_BOX_HEIGHT, h);
      if (ph == 3) begin
        write_reg(REG_SPARE_A, SIZE_MAX);
      end
      cfg_we <= 1'b0;
      no_gaps = (ph == 5);
      for (int n = 0; n < RAND_PER_SET; n++) begin
        queue_pose(random_coord(), random_coord(), random_heading());
      end
      drain_pipe();
    end

    repeat (PIPE_LATENCY + 4) @(negedge clk);
    if (pending_corners.size() != 0) begin
      $error("%0d results never arrived", pending_corners.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("rotated_box_corners: match");
    end else begin
      $display("rotated_box_corners: mismatch");
    end
    $finish;
  end

endmodule
